@@ rtl/byte_stream_cipher_keyed_defines.svh @@
`ifndef BYTE_STREAM_CIPHER_KEYED_DEFINES_SVH
`define BYTE_STREAM_CIPHER_KEYED_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset
`define BSCK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off during reset
`define BSCK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bsck_pkg.sv @@
`timescale 1ns / 1ps

package bsck_pkg;

    localparam int KEY_BYTES_DEF = 32;
    localparam int MIX_ROUNDS    = 256;

    typedef enum logic [1:0] {
        REQ_RESTART = 2'd0,
        REQ_KEY     = 2'd1,
        REQ_NONCE   = 2'd2,
        REQ_DATA    = 2'd3
    } req_t;

endpackage

@@ rtl/bsck_key_mem.sv @@
`timescale 1ns / 1ps

module bsck_key_mem #(
    parameter int DEPTH = bsck_pkg::KEY_BYTES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [7:0]    rdata_a,
    output logic [7:0]    rdata_b
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       qa_reg;
    logic [7:0]       qb_reg;
    logic             va_reg;
    logic             vb_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        qa_reg <= mem[raddr_a];
        qb_reg <= mem[raddr_b];
    end

    // An entry never written since restart reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            va_reg <= valid_reg[raddr_a];
            vb_reg <= valid_reg[raddr_b];
        end
    end

    assign rdata_a = va_reg ? qa_reg : 8'd0;
    assign rdata_b = vb_reg ? qb_reg : 8'd0;

endmodule

@@ rtl/byte_stream_cipher_keyed.sv @@
`timescale 1ns / 1ps

// Keyed byte stream cipher. Items carry a request type: restart, key byte,
// nonce byte or data byte; only a data byte yields a result item, its byte
// XORed with the next keystream byte (encrypt and decrypt are the same).
// The key array sits in a synchronous memory with a registered read, so
// every key, nonce or data item is read, then modified and written back.
// A restart is applied as it is accepted. A key or nonce item with last
// set then runs the 256 mixing rounds, which run one round per cycle with
// forwarding of the entry just written. Results wait in an output
// register; a data item holds in its write-back step while that register
// is full and stalled.

`include "byte_stream_cipher_keyed_defines.svh"

module byte_stream_cipher_keyed #(
    parameter int KEY_BYTES = bsck_pkg::KEY_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] req_type,
    input  logic [4:0] byte_index,
    input  logic [7:0] byte_value,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte
);

    localparam int AW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int CW = $clog2(bsck_pkg::MIX_ROUNDS);
    localparam logic [AW-1:0] LAST_E    = AW'(KEY_BYTES - 1);
    localparam logic [6:0]    KEY_LIMIT = 7'(KEY_BYTES);
    localparam logic [CW-1:0] MIX_LAST  = CW'(bsck_pkg::MIX_ROUNDS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MIX_START,
        ST_MIX
    } state_t;

    state_t          state_reg, state_next;
    bsck_pkg::req_t  req_reg, req_next;
    logic [4:0]      idx_reg, idx_next;
    logic [7:0]      val_reg, val_next;
    logic            last_reg, last_next;
    logic [7:0]      mixer_reg, mixer_next;
    logic [7:0]      pos_reg, pos_next;
    logic [AW-1:0]   e_reg, e_next;
    logic [AW-1:0]   mix_e_reg, mix_e_next;
    logic [CW-1:0]   mix_cnt_reg, mix_cnt_next;
    logic            fwd_sel_reg, fwd_sel_next;
    logic [7:0]      fwd_val_reg, fwd_val_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_byte_reg, out_byte_next;

    logic            mem_clear;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [7:0]      mem_wdata;
    logic [AW-1:0]   raddr_a;
    logic [AW-1:0]   f_addr;
    logic [7:0]      rdata_a;
    logic [7:0]      rdata_b;

    logic [AW-1:0]   mix_e_inc;
    logic            idx_ok;
    logic            out_block;
    logic [7:0]      mix_cur;
    logic [7:0]      mix_sum;
    logic [7:0]      key_sum;
    logic [7:0]      data_sum;

    bsck_key_mem #(
        .DEPTH (KEY_BYTES),
        .AW    (AW)
    ) u_key_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (mem_clear),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (raddr_a),
        .raddr_b (f_addr),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign f_addr    = (e_reg == LAST_E) ? '0 : e_reg + 1'b1;
    assign mix_e_inc = (mix_e_reg == LAST_E) ? '0 : mix_e_reg + 1'b1;
    assign idx_ok    = {2'b00, idx_reg} < KEY_LIMIT;
    assign out_block = out_valid_reg && out_stall;

    // Take the entry just written when the next round hits the same one
    assign mix_cur  = fwd_sel_reg ? fwd_val_reg : rdata_a;
    assign mix_sum  = mix_cur + mixer_reg;
    assign key_sum  = rdata_a + val_reg;
    assign data_sum = rdata_a + rdata_b + mixer_reg;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        mixer_next     = mixer_reg;
        pos_next       = pos_reg;
        e_next         = e_reg;
        mix_e_next     = mix_e_reg;
        mix_cnt_next   = mix_cnt_reg;
        fwd_sel_next   = fwd_sel_reg;
        fwd_val_next   = fwd_val_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        mem_clear      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = mix_e_reg;
        mem_wdata      = mix_sum;
        raddr_a        = e_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                raddr_a = (req_type == bsck_pkg::REQ_DATA) ? e_reg : AW'(byte_index);
                if (in_valid)
                begin
                    req_next  = bsck_pkg::req_t'(req_type);
                    idx_next  = byte_index;
                    val_next  = byte_value;
                    last_next = last;
                    if (req_type == bsck_pkg::REQ_RESTART)
                    begin
                        mem_clear  = 1'b1;
                        mixer_next = 8'd0;
                        pos_next   = 8'd0;
                        e_next     = '0;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                raddr_a = (req_reg == bsck_pkg::REQ_DATA) ? e_reg : AW'(idx_reg);
                if (req_reg == bsck_pkg::REQ_DATA)
                begin
                    // Hold until the output register can take the item
                    if (!out_block)
                    begin
                        mem_we         = 1'b1;
                        mem_waddr      = e_reg;
                        mem_wdata      = data_sum;
                        mixer_next     = mixer_reg + data_sum + pos_reg;
                        out_valid_next = 1'b1;
                        out_byte_next  = val_reg ^ data_sum;
                        pos_next       = pos_reg + 8'd1;
                        e_next         = (pos_reg == 8'hFF) ? '0 : f_addr;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    if (idx_ok)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = AW'(idx_reg);
                        mem_wdata  = key_sum;
                        mixer_next = mixer_reg + key_sum;
                    end
                    state_next = last_reg ? ST_MIX_START : ST_IDLE;
                end
            end
            ST_MIX_START:
            begin
                raddr_a      = '0;
                mix_e_next   = '0;
                mix_cnt_next = '0;
                fwd_sel_next = 1'b0;
                state_next   = ST_MIX;
            end
            ST_MIX:
            begin
                raddr_a      = mix_e_inc;
                mem_we       = 1'b1;
                mem_waddr    = mix_e_reg;
                mem_wdata    = mix_sum;
                mixer_next   = mixer_reg + mix_sum;
                mix_e_next   = mix_e_inc;
                fwd_sel_next = (mix_e_inc == mix_e_reg);
                fwd_val_next = mix_sum;
                mix_cnt_next = mix_cnt_reg + 1'b1;
                if (mix_cnt_reg == MIX_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            req_reg       <= bsck_pkg::REQ_RESTART;
            idx_reg       <= '0;
            val_reg       <= '0;
            last_reg      <= 1'b0;
            mixer_reg     <= '0;
            pos_reg       <= '0;
            e_reg         <= '0;
            mix_e_reg     <= '0;
            mix_cnt_reg   <= '0;
            fwd_sel_reg   <= 1'b0;
            fwd_val_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            idx_reg       <= idx_next;
            val_reg       <= val_next;
            last_reg      <= last_next;
            mixer_reg     <= mixer_next;
            pos_reg       <= pos_next;
            e_reg         <= e_next;
            mix_e_reg     <= mix_e_next;
            mix_cnt_reg   <= mix_cnt_next;
            fwd_sel_reg   <= fwd_sel_next;
            fwd_val_reg   <= fwd_val_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
        end
    end

    `BSCK_ASSERT_NOW(a_result_from_data, $rose(out_valid), ($past(state_reg) == ST_EXEC && $past(req_reg) == bsck_pkg::REQ_DATA), "result without a data item")
    `BSCK_ASSERT_NEXT(a_mix_ends, (state_reg == ST_MIX && mix_cnt_reg == MIX_LAST), (state_reg == ST_IDLE), "mixing did not end after last round")
    `BSCK_ASSERT_NEXT(a_data_advances, (state_reg == ST_EXEC && req_reg == bsck_pkg::REQ_DATA && !out_block), (out_valid && pos_reg == $past(pos_reg) + 8'd1), "data item did not advance keystream")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int NKEY         = bsck_pkg::KEY_BYTES_DEF;
    localparam int NUM_ITEMS    = 1650;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        bsck_pkg::req_t kind;
        logic [4:0]     idx;
        logic [7:0]     val;
        logic           lst;
    } cipher_req_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [1:0] req_type   = bsck_pkg::REQ_RESTART;
    logic [4:0] byte_index = '0;
    logic [7:0] byte_value = '0;
    logic       last       = 1'b0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic [7:0] out_byte;

    cipher_req_t pending_reqs[$];
    logic [7:0]  expected_bytes[$];

    // predictor state
    logic [7:0] key_mem[NKEY];
    logic [7:0] mix_acc;
    logic [7:0] pos_cnt;

    int          errors    = 0;
    int          send_gap  = 0;
    int          recv_hold = 0;
    int          quiet_cnt = 0;
    logic [15:0] cyc_cnt   = '0;

    wire in_fire  = in_valid && !in_stall;
    wire out_fire = out_valid && !out_stall;

    byte_stream_cipher_keyed u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .byte_index (byte_index),
        .byte_value (byte_value),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_cipher();
        for (int i = 0; i < NKEY; i++)
            key_mem[i] = 8'h00;
        mix_acc = 8'h00;
        pos_cnt = 8'h00;
    endfunction

    // Apply one accepted item to the predictor; a data item queues its keystream result.
    function automatic void advance_cipher(bsck_pkg::req_t kind, logic [4:0] idx,
                                           logic [7:0] val, logic lst);
        int e;
        int f;
        if (kind == bsck_pkg::REQ_RESTART)
        begin
            clear_cipher();
        end
        else if (kind == bsck_pkg::REQ_KEY || kind == bsck_pkg::REQ_NONCE)
        begin
            if (int'(idx) < NKEY)
            begin
                key_mem[idx] = key_mem[idx] + val;
                mix_acc      = mix_acc + key_mem[idx];
            end
            if (lst)
            begin
                for (int r = 0; r < bsck_pkg::MIX_ROUNDS; r++)
                begin
                    e          = r % NKEY;
                    key_mem[e] = key_mem[e] + mix_acc;
                    mix_acc    = mix_acc + key_mem[e];
                end
            end
        end
        else
        begin
            e          = int'(pos_cnt) % NKEY;
            f          = (int'(pos_cnt) + 1) % NKEY;
            key_mem[e] = key_mem[e] + key_mem[f] + mix_acc;
            mix_acc    = mix_acc + key_mem[e] + pos_cnt;
            expected_bytes.push_back(val ^ key_mem[e]);
            pos_cnt    = pos_cnt + 8'd1;
        end
    endfunction

    function automatic int pause_len(bit calm);
        return calm ? 0 : int'($urandom_range(0, 9));
    endfunction

    task automatic queue_req(bsck_pkg::req_t kind, logic [4:0] idx, logic [7:0] val,
                             logic lst);
        cipher_req_t r;
        r.kind = kind;
        r.idx  = idx;
        r.val  = val;
        r.lst  = lst;
        pending_reqs.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_in
        cipher_req_t nxt;
        int          wait_n;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            req_type   <= bsck_pkg::REQ_RESTART;
            byte_index <= '0;
            byte_value <= '0;
            last       <= 1'b0;
            send_gap   <= 0;
        end
        else
        begin
            wait_n = send_gap;
            if (in_fire)
            begin
                advance_cipher(bsck_pkg::req_t'(req_type), byte_index, byte_value, last);
                wait_n = pause_len(cyc_cnt[9:8] == 2'b11);
            end
            if (!in_valid || in_fire)
            begin
                if (wait_n > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= wait_n - 1;
                end
                else if (pending_reqs.size() != 0)
                begin
                    nxt = pending_reqs.pop_front();
                    req_type   <= nxt.kind;
                    byte_index <= nxt.idx;
                    byte_value <= nxt.val;
                    last       <= nxt.lst;
                    in_valid   <= 1'b1;
                    send_gap   <= 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    send_gap <= 0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch_out
        logic [7:0] want;
        int         hold_n;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_hold <= 0;
        end
        else
        begin
            hold_n = recv_hold;
            if (out_fire)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("out_byte: expected none, actual %0h", out_byte);
                    errors++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want)
                    begin
                        $error("out_byte: expected %0h, actual %0h", want, out_byte);
                        errors++;
                    end
                end
                hold_n = pause_len(cyc_cnt[10:9] == 2'b00);
            end
            else if (out_valid && hold_n > 0)
            begin
                // count the stall down only while a result is waiting
                hold_n = hold_n - 1;
            end
            recv_hold <= hold_n;
            out_stall <= (hold_n != 0);
        end
    end

    always @(posedge clk)
    begin
        cyc_cnt <= cyc_cnt + 16'd1;
        if (!rst_n || in_fire || out_fire)
        begin
            quiet_cnt <= 0;
        end
        else if (quiet_cnt >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    initial
    begin : stimulus
        int n_key;
        int n_nonce;
        int n_data;
        bit long_run;
        clear_cipher();
        long_run = 1'b1;

        // data straight out of reset, last on data and restart ignored
        queue_req(bsck_pkg::REQ_DATA,    5'd0,  8'h00, 1'b0);
        queue_req(bsck_pkg::REQ_DATA,    5'd31, 8'hFF, 1'b1);
        queue_req(bsck_pkg::REQ_RESTART, 5'd31, 8'hFF, 1'b1);
        queue_req(bsck_pkg::REQ_DATA,    5'd0,  8'h5A, 1'b0);
        // key and nonce bytes at both ends of the array, with wrap of the entry
        queue_req(bsck_pkg::REQ_KEY,     5'd0,  8'hFF, 1'b0);
        queue_req(bsck_pkg::REQ_KEY,     5'd31, 8'h01, 1'b0);
        queue_req(bsck_pkg::REQ_KEY,     5'd31, 8'hFF, 1'b0);
        queue_req(bsck_pkg::REQ_NONCE,   5'd0,  8'h80, 1'b0);
        queue_req(bsck_pkg::REQ_NONCE,   5'd16, 8'h7F, 1'b1);
        queue_req(bsck_pkg::REQ_DATA,    5'd0,  8'h55, 1'b0);
        queue_req(bsck_pkg::REQ_DATA,    5'd0,  8'hAA, 1'b0);
        queue_req(bsck_pkg::REQ_DATA,    5'd31, 8'hFF, 1'b0);
        queue_req(bsck_pkg::REQ_DATA,    5'd0,  8'h00, 1'b0);
        // back-to-back mixing passes
        queue_req(bsck_pkg::REQ_KEY,     5'd31, 8'h00, 1'b1);
        queue_req(bsck_pkg::REQ_NONCE,   5'd0,  8'h00, 1'b1);
        queue_req(bsck_pkg::REQ_DATA,    5'd7,  8'h01, 1'b0);
        queue_req(bsck_pkg::REQ_DATA,    5'd8,  8'h80, 1'b1);
        queue_req(bsck_pkg::REQ_DATA,    5'd9,  8'hC3, 1'b0);
        queue_req(bsck_pkg::REQ_RESTART, 5'd0,  8'h00, 1'b0);
        queue_req(bsck_pkg::REQ_DATA,    5'd0,  8'h3C, 1'b0);

        while (pending_reqs.size() < NUM_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                queue_req(bsck_pkg::req_t'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                          8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
            else
            begin
                if ($urandom_range(0, 4) != 0)
                    queue_req(bsck_pkg::REQ_RESTART, 5'($urandom_range(0, 31)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                n_key = $urandom_range(1, NKEY);
                for (int k = 0; k < n_key; k++)
                    queue_req(bsck_pkg::REQ_KEY, 5'($urandom_range(0, 31)),
                              8'($urandom_range(0, 255)), k == n_key - 1);
                n_nonce = $urandom_range(0, 12);
                for (int k = 0; k < n_nonce; k++)
                    queue_req(bsck_pkg::REQ_NONCE, 5'($urandom_range(0, 31)),
                              8'($urandom_range(0, 255)), k == n_nonce - 1);
                // some runs go past 256 data items so the position wraps
                if (long_run)
                    n_data = 300;
                else if ($urandom_range(0, 7) == 0)
                    n_data = $urandom_range(257, 300);
                else
                    n_data = $urandom_range(4, 60);
                long_run = 1'b0;
                for (int k = 0; k < n_data; k++)
                    queue_req(bsck_pkg::REQ_DATA, 5'($urandom_range(0, 31)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || in_valid || expected_bytes.size() != 0)
            @(negedge clk);
        // let a trailing mixing pass finish and catch any stray result
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
